// ----- rtl/asd_pkg.sv -----
// Package for the adaptive step detector: widths, register indexes, reset values
// and limits, the configuration record and a saturation helper used by the top level.
// No dependencies.
package asd_pkg;
  localparam int HistoryDepth = 4;
  localparam int HistIdxW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int HistCntW = $clog2(HistoryDepth + 1);
  localparam int IntervalW = 11;
  localparam int SumW = IntervalW + HistCntW;

  localparam logic [2:0] REG_FLOOR = 3'd0;
  localparam logic [2:0] REG_SENS = 3'd1;
  localparam logic [2:0] REG_ATTACK = 3'd2;
  localparam logic [2:0] REG_RELEASE = 3'd3;
  localparam logic [2:0] REG_STOP = 3'd4;
  localparam logic [2:0] REG_SKIPFRAC = 3'd5;
  localparam logic [2:0] REG_SKIPMIN = 3'd6;
  localparam logic [2:0] REG_SKIPMAX = 3'd7;

  localparam logic [19:0] Max20 = 20'hFFFFF;
  localparam logic [10:0] MaxInterval = 11'd2000;
  localparam logic [15:0] SkipReset = 16'd250;

  typedef struct packed {
    logic [16:0] floor_lvl;
    logic [7:0]  sens;
    logic [15:0] attack;
    logic [15:0] release_w;
    logic [15:0] stop_ms;
    logic [15:0] skip_frac;
    logic [15:0] skip_min;
    logic [15:0] skip_max;
  } cfg_t;

  function automatic logic [19:0] sat20(input logic [35:0] v);
    sat20 = (v > {16'd0, Max20}) ? Max20 : v[19:0];
  endfunction
endpackage

// ----- rtl/adaptive_step_detector.sv -----
// Adaptive step detector: one request in, one result out.
// Flow per request: 3 squaring steps, the 17-step square root, the 25-step shared
// divider when a rearm runs it, a step's peak and threshold update, and the history sum
// and divider average when an interval is stored.
// One request at a time; input ready only in idle, so a new request is taken only after
// the result is accepted. Synchronous active-high reset restores config, state and trackers.
module adaptive_step_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: time_ms[31:0], accel_x[47:32], accel_y[63:48], accel_z[79:64]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: step_detected[0], magnitude[17:1], threshold_now[37:18],
  //        peak_now[57:38], skip_now[73:58], zero fill to 80 bits
  output logic [79:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import asd_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ = 4'd1;
  localparam logic [3:0] ST_ROOT = 4'd2;
  localparam logic [3:0] ST_REARM = 4'd3;
  localparam logic [3:0] ST_DECIDE = 4'd4;
  localparam logic [3:0] ST_PK1 = 4'd5;
  localparam logic [3:0] ST_PK2 = 4'd6;
  localparam logic [3:0] ST_THR = 4'd7;
  localparam logic [3:0] ST_SUM = 4'd8;
  localparam logic [3:0] ST_AVG = 4'd9;
  localparam logic [3:0] ST_SKIP = 4'd10;
  localparam logic [3:0] ST_OUT = 4'd11;

  cfg_t cfg;
  logic [3:0] state;
  logic [31:0] t_ms, last_ms, since;
  logic signed [15:0] ax, ay, az;
  logic [1:0]  axis;
  logic [33:0] sumsq;
  logic [16:0] mag;
  logic [19:0] peak, thr;
  logic [15:0] skip;
  logic        rearm, seen, fired;
  logic [IntervalW-1:0] hist [HistoryDepth];
  logic [HistIdxW-1:0]  widx;
  logic        full;
  logic [HistCntW-1:0]  cnt, sidx;
  logic [SumW-1:0]      hsum;
  logic [35:0] acc;

  // Shared multiplier: one 20x17 product a cycle, operands chosen by state.
  logic [19:0] mul_a;
  logic [16:0] mul_b;
  logic [36:0] prod;
  logic signed [15:0] sq_op;
  logic [15:0] abs_op;
  logic [16:0] weight;

  logic        div_start, div_done, sq_start, sq_done;
  logic [24:0] div_dvd, div_q;
  logic [7:0]  div_dvs;
  logic [16:0] root;
  logic [IntervalW-1:0] iv;

  assign since = t_ms - last_ms;
  assign iv = since[IntervalW-1:0];
  assign sq_op = (axis == 2'd0) ? ax : (axis == 2'd1) ? ay : az;
  assign abs_op = sq_op[15] ? 16'(-sq_op) : sq_op;
  assign weight = ({3'd0, mag} > peak) ? {1'b0, cfg.attack} : {1'b0, cfg.release_w};

  always_comb begin
    mul_a = 20'd0;
    mul_b = 17'd0;
    case (state)
      ST_SQ: begin
        mul_a = {4'd0, abs_op};
        mul_b = {1'b0, abs_op};
      end
      ST_PK1: begin
        mul_a = {3'd0, mag};
        mul_b = weight;
      end
      ST_PK2: begin
        mul_a = peak;
        mul_b = 17'h10000 - weight;
      end
      ST_THR: begin
        mul_a = peak;
        mul_b = {9'd0, cfg.sens};
      end
      ST_SKIP: begin
        mul_a = {7'd0, div_q[12:0]};
        mul_b = {1'b0, cfg.skip_frac};
      end
      default: begin
        mul_a = 20'd0;
        mul_b = 17'd0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  asd_sqrt u_sqrt (.clk, .rst, .start(sq_start), .radicand(sumsq),
                   .done(sq_done), .root);
  asd_divider u_div (.clk, .rst, .start(div_start), .dividend(div_dvd),
                     .divisor(div_dvs), .done(div_done), .quotient(div_q));

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = {6'd0, skip, peak, thr, mag, fired};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_lvl <= 17'd2560;
      cfg.sens <= 8'd128;
      cfg.attack <= 16'd26214;
      cfg.release_w <= 16'd3277;
      cfg.stop_ms <= 16'd2000;
      cfg.skip_frac <= 16'd26214;
      cfg.skip_min <= 16'd150;
      cfg.skip_max <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLOOR: cfg.floor_lvl <= cfg_data;
        REG_SENS: cfg.sens <= cfg_data[7:0];
        REG_ATTACK: cfg.attack <= cfg_data[15:0];
        REG_RELEASE: cfg.release_w <= cfg_data[15:0];
        REG_STOP: cfg.stop_ms <= cfg_data[15:0];
        REG_SKIPFRAC: cfg.skip_frac <= cfg_data[15:0];
        REG_SKIPMIN: cfg.skip_min <= cfg_data[15:0];
        REG_SKIPMAX: cfg.skip_max <= cfg_data[15:0];
        default: cfg.floor_lvl <= cfg.floor_lvl;
      endcase
    end
  end

  // History store: entries only read once written, so no reset.
  always_ff @(posedge clk) begin
    if (state == ST_THR && seen && iv != '0 && since <= {21'd0, MaxInterval}) begin
      hist[widx] <= iv;
    end
  end

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    sq_start <= 1'b0;
    if (rst) begin
      state <= ST_IDLE;
      rearm <= 1'b1;
      seen <= 1'b0;
      last_ms <= 32'd0;
      skip <= SkipReset;
      widx <= '0;
      full <= 1'b0;
      peak <= 20'd0;
      thr <= 20'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            t_ms <= s_axis_tdata[31:0];
            ax <= s_axis_tdata[47:32];
            ay <= s_axis_tdata[63:48];
            az <= s_axis_tdata[79:64];
            axis <= 2'd0;
            sumsq <= 34'd0;
            fired <= 1'b0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          // Sum of three squares, one axis a cycle.
          sumsq <= sumsq + {2'd0, prod[31:0]};
          axis <= axis + 2'd1;
          if (axis == 2'd2) begin
            sq_start <= 1'b1;
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sq_done) begin
            mag <= root;
            if (rearm || since > {16'd0, cfg.stop_ms}) begin
              thr <= {3'd0, cfg.floor_lvl};
              rearm <= 1'b0;
              div_dvd <= {cfg.floor_lvl, 8'd0};
              div_dvs <= cfg.sens;
              if (cfg.sens == 8'd0) begin
                peak <= Max20;
                state <= ST_DECIDE;
              end else begin
                div_start <= 1'b1;
                state <= ST_REARM;
              end
            end else begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_REARM: begin
          if (div_done) begin
            peak <= sat20({11'd0, div_q});
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (17'(mag) > 17'(0) && {3'd0, mag} > thr && since > {16'd0, skip}) begin
            fired <= 1'b1;
            state <= ST_PK1;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_PK1: begin
          acc <= {15'd0, prod[36:16]};
          state <= ST_PK2;
        end
        ST_PK2: begin
          peak <= sat20(acc + {15'd0, prod[36:16]});
          state <= ST_THR;
        end
        ST_THR: begin
          last_ms <= t_ms;
          seen <= 1'b1;
          if (prod[27:8] < {3'd0, cfg.floor_lvl}) thr <= {3'd0, cfg.floor_lvl};
          else thr <= prod[27:8];
          if (seen && iv != '0 && since <= {21'd0, MaxInterval}) begin
            widx <= (widx == HistIdxW'(HistoryDepth - 1)) ? '0 : widx + 1'b1;
            if (widx == HistIdxW'(HistoryDepth - 1)) full <= 1'b1;
            cnt <= (full || widx == HistIdxW'(HistoryDepth - 1)) ?
                   HistCntW'(HistoryDepth) : HistCntW'(widx) + 1'b1;
            sidx <= '0;
            hsum <= '0;
            state <= ST_SUM;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_SUM: begin
          // Accumulate written history entries, one a cycle.
          hsum <= hsum + SumW'(hist[sidx[HistIdxW-1:0]]);
          sidx <= sidx + 1'b1;
          if (sidx + 1'b1 == cnt) begin
            div_dvd <= 25'(hsum + SumW'(hist[sidx[HistIdxW-1:0]]));
            div_dvs <= 8'(cnt);
            div_start <= 1'b1;
            state <= ST_AVG;
          end
        end
        ST_AVG: begin
          if (div_done) state <= ST_SKIP;
        end
        ST_SKIP: begin
          if (prod[31:16] < cfg.skip_min) begin
            skip <= (cfg.skip_min > cfg.skip_max) ? cfg.skip_max : cfg.skip_min;
          end else if (prod[31:16] > cfg.skip_max) begin
            skip <= cfg.skip_max;
          end else begin
            skip <= prod[31:16];
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result held");
  a_fire_stamp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_THR) |=> (last_ms == $past(t_ms) && seen))
    else $error("step time not recorded");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while waiting");
endmodule

// ----- rtl/asd_divider.sv -----
// Shared restoring divider, one quotient bit a cycle, 25-bit dividend.
// Used for the rearm peak and the interval average. Depends on asd_pkg.
module asd_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [24:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [24:0] quotient
);
  import asd_pkg::*;

  logic [24:0] rem_q;
  logic [24:0] quo;
  logic [4:0]  count;
  logic        busy;
  logic [25:0] trial;
  logic [25:0] shifted;

  assign shifted = {rem_q, quo[24]};
  assign trial = shifted - {18'd0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 5'd25;
        rem_q <= 25'd0;
        quo <= dividend;
      end else if (busy) begin
        if (!trial[25]) begin
          rem_q <= trial[24:0];
          quo <= {quo[23:0], 1'b1};
        end else begin
          rem_q <= shifted[24:0];
          quo <= {quo[23:0], 1'b0};
        end
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/asd_sqrt.sv -----
// Bit-pair integer square root of a 34-bit sum of squares.
// Depends on asd_pkg.
module asd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] radicand,
  output logic        done,
  output logic [16:0] root
);
  import asd_pkg::*;

  logic [33:0] rad;
  logic [18:0] rem_q;
  logic [16:0] res;
  logic [4:0]  count;
  logic        busy;
  logic [18:0] cur;
  logic [18:0] trial;

  assign cur = {rem_q[16:0], rad[33:32]};
  assign trial = cur - {res, 2'b01};
  assign root = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 5'd17;
        rad <= radicand;
        rem_q <= 19'd0;
        res <= 17'd0;
      end else if (busy) begin
        rad <= {rad[31:0], 2'b00};
        if (!trial[18]) begin
          rem_q <= trial;
          res <= {res[15:0], 1'b1};
        end else begin
          rem_q <= cur;
          res <= {res[15:0], 1'b0};
        end
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
